>>> sv/og3d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// og3d_pkg: shared types and constants of the 3d occupancy grid
// register map, opcodes, configuration bundle and field widths
// ----------------------------------------------------------------------------
package og3d_pkg;

  localparam int CELLS_PER_AXIS_DEF = 64;

  localparam int COORD_W    = 32;
  localparam int CNT_REG_W  = 7;
  localparam int CELL_OUT_W = 6;
  localparam int OPC_W      = 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int IN_TDATA_W   = 3 * COORD_W;
  localparam int OUT_FIELDS_W = 2 + 3 * CELL_OUT_W + 3 * COORD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 4;

  localparam logic [COORD_W-1:0]   ORIGIN_RST    = '0;
  localparam logic [COORD_W-1:0]   CELL_SIZE_RST = 32'h0001_0000;
  localparam logic [COORD_W-1:0]   INV_SIZE_RST  = 32'h0001_0000;
  localparam logic [CNT_REG_W-1:0] CELLS_RST     = 7'd64;

  typedef enum logic [OPC_W-1:0] {
    OP_MARK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_ROUND = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_CELL_SIZE = 3'd3,
    REG_INV_SIZE  = 3'd4,
    REG_CELLS_X   = 3'd5,
    REG_CELLS_Y   = 3'd6,
    REG_CELLS_Z   = 3'd7
  } reg_idx_e;

  // axis 0 is x, 1 is y, 2 is z
  typedef struct packed {
    logic [2:0][COORD_W-1:0]   origin;
    logic [COORD_W-1:0]        cell_size;
    logic [COORD_W-1:0]        inv_size;
    logic [2:0][CNT_REG_W-1:0] cells;
  } cfg_t;

endpackage
`default_nettype wire

>>> sv/og3d_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// og3d_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module og3d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/og3d_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// og3d_fifo: command queue between front and back
// small register fifo, power-of-two depth
// ----------------------------------------------------------------------------
module og3d_fifo
  import og3d_pkg::*;
#(
  parameter int W     = 21,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output      logic [W-1:0] data_o,
  output      logic         full_o,
  output      logic         empty_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [W-1:0]   buf_q [DEPTH];
  logic [PTR_W:0] wr_q;
  logic [PTR_W:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q[PTR_W-1:0]] <= data_i;
    end
  end

  assign data_o  = buf_q[rd_q[PTR_W-1:0]];
  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[PTR_W] != rd_q[PTR_W]) && (wr_q[PTR_W-1:0] == rd_q[PTR_W-1:0]);

endmodule
`default_nettype wire

>>> sv/og3d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// og3d_front: point quantizer and classifier
// offset from origin, scale by inverse cell size, range check and clamp
// ----------------------------------------------------------------------------
module og3d_front
  import og3d_pkg::*;
#(
  parameter int CELLS_PER_AXIS = CELLS_PER_AXIS_DEF,
  parameter int IDX_W          = $clog2(CELLS_PER_AXIS),
  parameter int CMD_W          = OPC_W + 1 + 3 * IDX_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfg_t                    cfg_i,
  input  wire logic                    s_valid_i,
  output      logic                    s_ready_o,
  input  wire logic [OPC_W-1:0]        op_i,
  input  wire logic [2:0][COORD_W-1:0] point_i,
  input  wire logic                    store_ready_i,
  output      logic                    push_o,
  output      logic [CMD_W-1:0]        cmd_o,
  input  wire logic                    full_i
);

  localparam int CNT_W = ($clog2(CELLS_PER_AXIS + 1) > CNT_REG_W) ?
                         $clog2(CELLS_PER_AXIS + 1) : CNT_REG_W;

  typedef struct packed {
    logic [OPC_W-1:0]      op;
    logic                  acc;
    logic [2:0][IDX_W-1:0] idx;
  } cmd_t;

  // stage a: offset from origin
  logic                      a_valid_q;
  logic [OPC_W-1:0]          a_op_q;
  logic [2:0][COORD_W:0]     a_diff_q;
  // stage b: raw cell index
  logic                      b_valid_q;
  logic [OPC_W-1:0]          b_op_q;
  logic [2:0]                b_neg_q;
  logic [2:0][COORD_W-1:0]   b_raw_q;

  logic                      adv_a;
  logic                      adv_b;
  logic                      ready_a;
  logic                      ready_b;
  logic                      take;
  logic [2:0][COORD_W:0]     diff;
  logic [2:0][2*COORD_W-1:0] prod;
  logic [2:0]                in_rng;
  cmd_t                      cmd;

  function automatic logic [CNT_W-1:0] eff_cells(input logic [CNT_REG_W-1:0] c);
    logic [CNT_W-1:0] ce;
    ce = CNT_W'(c);
    if (ce == '0) begin
      return CNT_W'(1);
    end else if (ce > CNT_W'(CELLS_PER_AXIS)) begin
      return CNT_W'(CELLS_PER_AXIS);
    end
    return ce;
  endfunction

  assign adv_b     = b_valid_q && !full_i;
  assign ready_b   = !b_valid_q || adv_b;
  assign adv_a     = a_valid_q && ready_b;
  assign ready_a   = !a_valid_q || adv_a;
  assign s_ready_o = ready_a && store_ready_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {point_i[a][COORD_W-1], point_i[a]} -
                {cfg_i.origin[a][COORD_W-1], cfg_i.origin[a]};
      prod[a] = (2*COORD_W)'(a_diff_q[a][COORD_W-1:0]) * (2*COORD_W)'(cfg_i.inv_size);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid_q <= take;
      end
      if (ready_b) begin
        b_valid_q <= adv_a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_op_q   <= op_i;
      a_diff_q <= diff;
    end
    if (adv_a) begin
      b_op_q <= a_op_q;
      for (int a = 0; a < 3; a++) begin
        b_neg_q[a] <= a_diff_q[a][COORD_W];
        b_raw_q[a] <= prod[a][2*COORD_W-1:COORD_W];
      end
    end
  end

  // below the origin means index 0; past the count clamps to the last cell
  always_comb begin
    logic [CNT_W-1:0] n;
    cmd.op = b_op_q;
    for (int a = 0; a < 3; a++) begin
      n = eff_cells(cfg_i.cells[a]);
      in_rng[a] = !b_neg_q[a] && (b_raw_q[a] < COORD_W'(n));
      if (b_neg_q[a]) begin
        cmd.idx[a] = '0;
      end else if (b_raw_q[a] >= COORD_W'(n)) begin
        cmd.idx[a] = IDX_W'(n - CNT_W'(1));
      end else begin
        cmd.idx[a] = b_raw_q[a][IDX_W-1:0];
      end
    end
    cmd.acc = (b_op_q == OP_MARK) && (&in_rng);
  end

  assign push_o = adv_b;
  assign cmd_o  = cmd;

endmodule
`default_nettype wire

>>> sv/og3d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// og3d_back: occupancy store sequencer
// clears the store, then runs read-modify-write, lookup and centre per command
// ----------------------------------------------------------------------------
module og3d_back
  import og3d_pkg::*;
#(
  parameter int CELLS_PER_AXIS = CELLS_PER_AXIS_DEF,
  parameter int IDX_W          = $clog2(CELLS_PER_AXIS),
  parameter int CMD_W          = OPC_W + 1 + 3 * IDX_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   empty_i,
  input  wire logic [CMD_W-1:0]       cmd_i,
  output      logic                   pop_o,
  output      logic                   ready_o,
  output      logic                   m_valid_o,
  input  wire logic                   m_ready_i,
  output      logic [OUT_TDATA_W-1:0] m_data_o
);

  localparam int ROWS  = CELLS_PER_AXIS * CELLS_PER_AXIS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int PW    = IDX_W + 1 + COORD_W;

  typedef struct packed {
    logic [OPC_W-1:0]      op;
    logic                  acc;
    logic [2:0][IDX_W-1:0] idx;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e                  state_q;
  logic [ROW_W-1:0]        clr_q;
  cmd_t                    cmd_q;
  logic [ROW_W-1:0]        row_q;
  logic                    free_q;
  logic [2:0][COORD_W-1:0] off_q;
  logic                    m_valid_q;
  logic                    m_valid_d;
  logic [OUT_TDATA_W-1:0]  m_data_q;

  cmd_t                    head;
  logic [ROW_W-1:0]        head_row;
  logic                    ram_we;
  logic [ROW_W-1:0]        ram_waddr;
  logic [CELLS_PER_AXIS-1:0] ram_wdata;
  logic [CELLS_PER_AXIS-1:0] ram_rdata;
  logic [CELLS_PER_AXIS-1:0] bit_mask;
  logic [2:0][PW-1:0]      prod;
  logic [OUT_TDATA_W-1:0]  res;

  assign head     = cmd_i;
  assign head_row = ROW_W'(ROW_W'(head.idx[0]) * ROW_W'(CELLS_PER_AXIS)) +
                    ROW_W'(head.idx[1]);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign ready_o  = (state_q != ST_CLEAR);
  assign bit_mask = {{(CELLS_PER_AXIS-1){1'b0}}, 1'b1} << cmd_q.idx[2];

  // result register holds while stalled, loads in ST_OUT
  assign m_valid_d = (state_q == ST_OUT) || (m_valid_q && !m_ready_i);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_q;
    ram_wdata = ram_rdata | bit_mask;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == ST_EXEC) begin
      ram_we = (cmd_q.op == OP_MARK) && cmd_q.acc;
    end
  end

  og3d_ram #(
    .WIDTH (CELLS_PER_AXIS),
    .DEPTH (ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (head_row),
    .rdata_o (ram_rdata)
  );

  // centre offset: (2*idx + 1) * cell_size / 2
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = PW'({cmd_q.idx[a], 1'b1}) * PW'(cfg_i.cell_size);
    end
  end

  always_comb begin
    logic                          acc_b;
    logic                          free_b;
    logic [2:0][CELL_OUT_W-1:0]    cell_b;
    logic [2:0][COORD_W-1:0]       ctr_b;
    acc_b  = 1'b0;
    free_b = 1'b0;
    cell_b = '0;
    ctr_b  = '0;
    unique case (cmd_q.op)
      OP_MARK: begin
        acc_b = cmd_q.acc;
        if (cmd_q.acc) begin
          for (int a = 0; a < 3; a++) cell_b[a] = CELL_OUT_W'(cmd_q.idx[a]);
        end
      end
      OP_QUERY: begin
        free_b = free_q;
        for (int a = 0; a < 3; a++) cell_b[a] = CELL_OUT_W'(cmd_q.idx[a]);
      end
      OP_ROUND: begin
        for (int a = 0; a < 3; a++) begin
          cell_b[a] = CELL_OUT_W'(cmd_q.idx[a]);
          ctr_b[a]  = cfg_i.origin[a] + off_q[a];
        end
      end
      default: begin
        acc_b = 1'b0;
      end
    endcase
    res = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, ctr_b[2], ctr_b[1], ctr_b[0],
           cell_b[2], cell_b[1], cell_b[0], free_b, acc_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cmd_q     <= '0;
      row_q     <= '0;
      free_q    <= 1'b0;
      off_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ROW_W'(ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty_i) begin
            cmd_q   <= head;
            row_q   <= head_row;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          free_q <= ~ram_rdata[cmd_q.idx[2]];
          for (int a = 0; a < 3; a++) begin
            off_q[a] <= prod[a][COORD_W:1];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_ready_i) begin
            m_data_q <= res;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule
`default_nettype wire

>>> sv/occupancy_grid_3d_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_grid_3d_top: 3d voxel occupancy grid
// marks, queries and rounds signed q16.16 points against a bit-per-cell store
// ----------------------------------------------------------------------------
//
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tuser opcode, tdata point x/y/z
//  m_axis    | out       | tdata accepted, is_free, cell x/y/z, centre x/y/z
//  apb       | in/out    | origin, cell size, inverse size, cell counts
//
//  a command passes the front pipeline (offset, scale; classify on the
//  push), the command queue and the back (store read, execute/modify-write);
//  the back steps through pop, execute and result states per command and
//  takes no new command until the last result is loaded
//  after reset the store is swept clear, one row of cells per cycle,
//  CELLS_PER_AXIS^2 rows (4096 at 64); s_axis_tready stays low until done
//  a stalled m_axis holds the back; the front keeps taking transactions until
//  the command queue and its own stages fill
//
module occupancy_grid_3d_top
  import og3d_pkg::*;
#(
  parameter int CELLS_PER_AXIS = CELLS_PER_AXIS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // point_x, point_y, point_z
  input  wire logic [OPC_W-1:0]       s_axis_tuser,   // opcode
  // result stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,   // accepted, is_free, cell_x,
                                                      // cell_y, cell_z, centre_x,
                                                      // centre_y, centre_z, zero pad
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output      logic [APB_DATA_W-1:0]  prdata,
  output      logic                   pready
);

  localparam int IDX_W = $clog2(CELLS_PER_AXIS);
  localparam int CMD_W = OPC_W + 1 + 3 * IDX_W;

  cfg_t                    cfg_q;
  reg_idx_e                reg_idx;
  logic                    cfg_wr;
  logic [2:0][COORD_W-1:0] point;

  logic                    push;
  logic                    pop;
  logic                    q_full;
  logic                    q_empty;
  logic [CMD_W-1:0]        push_cmd;
  logic [CMD_W-1:0]        pop_cmd;
  logic                    store_ready;

  // register file: index is the word address
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin    <= {ORIGIN_RST, ORIGIN_RST, ORIGIN_RST};
      cfg_q.cell_size <= CELL_SIZE_RST;
      cfg_q.inv_size  <= INV_SIZE_RST;
      cfg_q.cells     <= {CELLS_RST, CELLS_RST, CELLS_RST};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X:  cfg_q.origin[0] <= pwdata;
        REG_ORIGIN_Y:  cfg_q.origin[1] <= pwdata;
        REG_ORIGIN_Z:  cfg_q.origin[2] <= pwdata;
        REG_CELL_SIZE: cfg_q.cell_size <= pwdata;
        REG_INV_SIZE:  cfg_q.inv_size  <= pwdata;
        REG_CELLS_X:   cfg_q.cells[0]  <= pwdata[CNT_REG_W-1:0];
        REG_CELLS_Y:   cfg_q.cells[1]  <= pwdata[CNT_REG_W-1:0];
        REG_CELLS_Z:   cfg_q.cells[2]  <= pwdata[CNT_REG_W-1:0];
        default:       cfg_q.cells[2]  <= cfg_q.cells[2];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:  prdata = cfg_q.origin[0];
      REG_ORIGIN_Y:  prdata = cfg_q.origin[1];
      REG_ORIGIN_Z:  prdata = cfg_q.origin[2];
      REG_CELL_SIZE: prdata = cfg_q.cell_size;
      REG_INV_SIZE:  prdata = cfg_q.inv_size;
      REG_CELLS_X:   prdata = APB_DATA_W'(cfg_q.cells[0]);
      REG_CELLS_Y:   prdata = APB_DATA_W'(cfg_q.cells[1]);
      REG_CELLS_Z:   prdata = APB_DATA_W'(cfg_q.cells[2]);
      default:       prdata = '0;
    endcase
  end

  // point fields, x in the low word
  assign point = s_axis_tdata;

  og3d_front #(
    .CELLS_PER_AXIS (CELLS_PER_AXIS),
    .IDX_W          (IDX_W),
    .CMD_W          (CMD_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .op_i          (s_axis_tuser),
    .point_i       (point),
    .store_ready_i (store_ready),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (q_full)
  );

  og3d_fifo #(
    .W     (CMD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  og3d_back #(
    .CELLS_PER_AXIS (CELLS_PER_AXIS),
    .IDX_W          (IDX_W),
    .CMD_W          (CMD_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (q_empty),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .ready_o   (store_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
